// File: hdl/sclp_pkg.sv
// ----------------------------------------------------------------------------
// sclp_pkg: shared types and codes of the statement cache
// Entry layout carried along the cell chain, action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sclp_pkg;

	localparam logic [1:0] ACT_LOOKUP    = 2'd0;
	localparam logic [1:0] ACT_ADD       = 2'd1;
	localparam logic [1:0] ACT_CLEAR_REL = 2'd2;
	localparam logic [1:0] ACT_CLEAR_LOC = 2'd3;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_UPDATED  = 3'd3;
	localparam logic [2:0] ST_REPLACED = 3'd4;
	localparam logic [2:0] ST_REJECTED = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	localparam logic [5:0] COUNT_MAX = 6'd63;

	// One table entry; key zero marks an empty slot.
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] name;
		logic [15:0] pcount;
		logic [31:0] stamp;
	} entry_t;

endpackage

`default_nettype wire

// File: hdl/sclp_req_if.sv
// ----------------------------------------------------------------------------
// sclp_req_if: request channel of the statement cache
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sclp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [63:0] key;
	logic [31:0] name_id;
	logic [15:0] n_params;
	logic [31:0] now;
	logic        connected;

	modport source (output valid, action, key, name_id, n_params, now, connected,
		input ready);
	modport sink (input valid, action, key, name_id, n_params, now, connected,
		output ready);
endinterface

`default_nettype wire

// File: hdl/sclp_rsp_if.sv
// ----------------------------------------------------------------------------
// sclp_rsp_if: result channel of the statement cache
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sclp_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  slot;
	logic [31:0] found_name;
	logic        release_res;
	logic [5:0]  occupied;
	logic        last;

	modport source (output valid, status, slot, found_name, release_res, occupied, last,
		input ready);
	modport sink (input valid, status, slot, found_name, release_res, occupied, last,
		output ready);
endinterface

`default_nettype wire

// File: hdl/sclp_cell.sv
// ----------------------------------------------------------------------------
// sclp_cell: one table entry of the rotating cell chain
// Takes its neighbor's entry on shift; clear empties it.
// ----------------------------------------------------------------------------
`default_nettype none

module sclp_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire logic            clear,
	input  wire sclp_pkg::entry_t din,
	output sclp_pkg::entry_t     dout
);

	logic [63:0] key_q;
	logic [31:0] stamp_q;
	logic [31:0] name_q;
	logic [15:0] pcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			stamp_q <= '0;
		end else if (clear) begin
			key_q   <= '0;
			stamp_q <= '0;
		end else if (shift) begin
			key_q   <= din.key;
			stamp_q <= din.stamp;
		end
	end

	// payload only; meaningless while the key is zero
	always_ff @(posedge clk) begin
		if (shift && !clear) begin
			name_q   <= din.name;
			pcount_q <= din.pcount;
		end
	end

	assign dout = '{key: key_q, name: name_q, pcount: pcount_q, stamp: stamp_q};

endmodule

`default_nettype wire

// File: hdl/statement_cache_linear_probe_lru_unit.sv
// ----------------------------------------------------------------------------
// statement_cache_linear_probe_lru_unit: prepared-statement cache
// Open-addressed table of ENTRIES slots with linear probing and LRU eviction.
// ----------------------------------------------------------------------------
// The table lives in a ring of ENTRIES cells that rotates one place per cycle
// while it shifts (scan, write and release passes; release stalls on the
// result channel); cell 0 is the read/write head and holds slot t at step t
// of a pass. A lookup or add takes one scan pass that finds the first
// empty-or-matching slot from home and the oldest entry, then one write pass
// that patches the target slot as it passes the head, then posts the result.
// When ENTRIES is not a power of two the home slot is reduced first by a
// byte-weighted sum of the key and a reciprocal multiply. A clear with
// release while connected takes one pass that posts a result per occupied
// slot, stalling on the result channel, and then a final one; other clears
// and a zero key post their result directly. Any item also waits while the
// previous result still sits unread in the output register. One request item
// is worked on at a time; a finished result sits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module statement_cache_linear_probe_lru_unit #(
	parameter int ENTRIES = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sclp_req_if.sink  req,
	sclp_rsp_if.source rsp
);

	// weight of key byte j: 2^(8j) mod ENTRIES, elaboration only
	function automatic logic [9:0] byte_weight(input int j);
		int w;
		w = 1 % ENTRIES;
		for (int k = 0; k < 8 * j; k++) begin
			w = (w * 2) % ENTRIES;
		end
		return 10'(w);
	endfunction

	localparam int  IW      = $clog2(ENTRIES);
	localparam bit  IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [IW:0]   N_EXT    = (IW + 1)'(ENTRIES);
	localparam logic [20:0]   QN       = 21'(ENTRIES);
	// ceil(2^32 / ENTRIES): exact quotient for sums below 2^21
	localparam logic [31:0]   RECIP    =
		32'(((64'd1 << 32) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
	localparam logic [9:0] BW0 = byte_weight(0);
	localparam logic [9:0] BW1 = byte_weight(1);
	localparam logic [9:0] BW2 = byte_weight(2);
	localparam logic [9:0] BW3 = byte_weight(3);
	localparam logic [9:0] BW4 = byte_weight(4);
	localparam logic [9:0] BW5 = byte_weight(5);
	localparam logic [9:0] BW6 = byte_weight(6);
	localparam logic [9:0] BW7 = byte_weight(7);

	typedef enum logic [2:0] {
		S_IDLE, S_HOME, S_SCAN, S_WRITE, S_DONE, S_RELEASE, S_FINAL, S_REJECT
	} state_t;

	// slot field is the index modulo 32
	function automatic logic [4:0] to_slot(input logic [IW-1:0] idx);
		logic [IW+4:0] ext;
		ext = (IW + 5)'(idx);
		return ext[4:0];
	endfunction

	state_t state_q;

	// captured request item
	logic [1:0]  act_q;
	logic [63:0] key_q;
	logic [31:0] name_q;
	logic [15:0] pcount_q;
	logic [31:0] now_q;
	logic        conn_q;

	logic [IW-1:0] home_q;
	logic [20:0]   acc_q;     // byte-weighted key sum
	logic [20:0]   quo_q;     // acc_q / ENTRIES
	logic [5:0]    bit_q;     // home reduction step
	logic [IW-1:0] t_q;       // slot at the head

	// first empty-or-matching slot, by probe distance
	logic          stop_have_q;
	logic [IW-1:0] stop_d_q;
	logic [IW-1:0] stop_slot_q;
	logic          stop_match_q;
	logic [31:0]   stop_name_q;

	// oldest candidate, ties to smaller probe distance
	logic          old_have_q;
	logic [IW-1:0] old_d_q;
	logic [IW-1:0] old_slot_q;
	logic [31:0]   old_stamp_q;
	logic [31:0]   old_name_q;

	logic [5:0] count_q;

	// result register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [4:0]  out_slot_q;
	logic [31:0] out_name_q;
	logic        out_rel_q;
	logic [5:0]  out_occ_q;
	logic        out_last_q;

	// ring
	sclp_pkg::entry_t cell_in  [ENTRIES];
	sclp_pkg::entry_t cell_out [ENTRIES];
	sclp_pkg::entry_t head;
	sclp_pkg::entry_t head_mod;
	logic             shift_en;
	logic             clear_all;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			if (gi == ENTRIES - 1) begin : g_tail
				assign cell_in[gi] = head_mod;
			end else begin : g_mid
				assign cell_in[gi] = cell_out[gi + 1];
			end
			sclp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift_en),
				.clear  (clear_all),
				.din    (cell_in[gi]),
				.dout   (cell_out[gi])
			);
		end
	endgenerate

	assign head = cell_out[0];

	logic          can_load;
	logic          accept;
	logic          load_out;
	logic [IW:0]   d_ext;
	logic [IW-1:0] probe_d;
	logic          stop_here;
	logic          old_take;
	logic          hit;
	logic          wen;
	logic [IW-1:0] target;
	logic          last_step;
	logic [IW-1:0] t_next;
	logic [7:0]    key_byte;
	logic [9:0]    byte_w;
	logic [17:0]   byte_part;
	logic [20:0]   acc_next;
	logic [52:0]   recip_prod;
	logic [20:0]   fold_rem;
	logic [5:0]    count_inc;

	assign can_load  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign last_step = (t_q == LAST_IDX);
	assign t_next    = last_step ? '0 : t_q + 1'b1;

	// probe distance of the head slot from home
	always_comb begin
		if (t_q >= home_q) begin
			d_ext = {1'b0, t_q} - {1'b0, home_q};
		end else begin
			d_ext = {1'b0, t_q} + N_EXT - {1'b0, home_q};
		end
		probe_d = d_ext[IW-1:0];
	end

	assign stop_here = (head.key == '0) || (head.key == key_q);
	assign old_take  = ((head.key != '0) || (probe_d == '0)) &&
		(!old_have_q || (head.stamp < old_stamp_q) ||
		((head.stamp == old_stamp_q) && (probe_d < old_d_q)));

	assign hit = stop_have_q && stop_match_q;

	always_comb begin
		if (act_q == sclp_pkg::ACT_LOOKUP) begin
			wen    = hit;
			target = stop_slot_q;
		end else begin
			wen    = 1'b1;
			target = stop_have_q ? stop_slot_q : old_slot_q;
		end
	end

	// head patch during the write pass
	always_comb begin
		head_mod = head;
		if (state_q == S_WRITE && wen && t_q == target) begin
			head_mod.stamp = now_q;
			if (act_q == sclp_pkg::ACT_ADD) begin
				head_mod.key    = key_q;
				head_mod.name   = name_q;
				head_mod.pcount = pcount_q;
			end
		end
	end

	always_comb begin
		unique case (state_q)
			S_SCAN, S_WRITE: shift_en = 1'b1;
			S_RELEASE:       shift_en = (head.key == '0) || can_load;
			default:         shift_en = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_DONE, S_FINAL, S_REJECT: load_out = can_load;
			S_RELEASE:                 load_out = shift_en && (head.key != '0);
			default:                   load_out = 1'b0;
		endcase
	end

	assign clear_all = (state_q == S_FINAL) && can_load;

	// home reduction: sum of key bytes times 2^(8j) mod ENTRIES, then divide
	always_comb begin
		case (bit_q[2:0])
			3'd0: byte_w = BW0;
			3'd1: byte_w = BW1;
			3'd2: byte_w = BW2;
			3'd3: byte_w = BW3;
			3'd4: byte_w = BW4;
			3'd5: byte_w = BW5;
			3'd6: byte_w = BW6;
			3'd7: byte_w = BW7;
		endcase
	end

	assign key_byte   = key_q[{bit_q[2:0], 3'b000} +: 8];
	assign byte_part  = {10'b0, key_byte} * {8'b0, byte_w};
	assign acc_next   = acc_q + {3'b0, byte_part};
	assign recip_prod = {32'b0, acc_q} * {21'b0, RECIP};
	assign fold_rem   = acc_q - quo_q * QN;
	assign count_inc  = (count_q < sclp_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			t_q         <= '0;
			stop_have_q <= 1'b0;
			old_have_q  <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q       <= req.action;
						key_q       <= req.key;
						name_q      <= req.name_id;
						pcount_q    <= req.n_params;
						now_q       <= req.now;
						conn_q      <= req.connected;
						t_q         <= '0;
						stop_have_q <= 1'b0;
						old_have_q  <= 1'b0;
						acc_q       <= '0;
						bit_q       <= '0;
						home_q      <= req.key[IW-1:0];
						if (req.action == sclp_pkg::ACT_CLEAR_REL && req.connected) begin
							state_q <= S_RELEASE;
						end else if (req.action == sclp_pkg::ACT_CLEAR_REL ||
							req.action == sclp_pkg::ACT_CLEAR_LOC) begin
							state_q <= S_FINAL;
						end else if (req.key == '0) begin
							state_q <= S_REJECT;
						end else if (IS_POW2) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_HOME;
						end
					end
				end
				S_HOME: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q < 6'd8) begin
						acc_q <= acc_next;
					end else if (bit_q == 6'd8) begin
						quo_q <= recip_prod[52:32];
					end else begin
						home_q  <= fold_rem[IW-1:0];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stop_here && (!stop_have_q || probe_d < stop_d_q)) begin
						stop_have_q  <= 1'b1;
						stop_d_q     <= probe_d;
						stop_slot_q  <= t_q;
						stop_match_q <= (head.key != '0);
						stop_name_q  <= head.name;
					end
					if (old_take) begin
						old_have_q  <= 1'b1;
						old_d_q     <= probe_d;
						old_slot_q  <= t_q;
						old_stamp_q <= head.stamp;
						old_name_q  <= head.name;
					end
					t_q <= t_next;
					if (last_step) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					t_q <= t_next;
					if (last_step) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_load) begin
						out_last_q <= 1'b1;
						if (act_q == sclp_pkg::ACT_LOOKUP) begin
							out_rel_q <= 1'b0;
							out_occ_q <= count_q;
							if (hit) begin
								out_status_q <= sclp_pkg::ST_HIT;
								out_slot_q   <= to_slot(stop_slot_q);
								out_name_q   <= stop_name_q;
							end else begin
								out_status_q <= sclp_pkg::ST_MISS;
								out_slot_q   <= '0;
								out_name_q   <= '0;
							end
						end else if (stop_have_q) begin
							out_slot_q <= to_slot(stop_slot_q);
							out_name_q <= '0;
							out_rel_q  <= 1'b0;
							if (stop_match_q) begin
								out_status_q <= sclp_pkg::ST_UPDATED;
								out_occ_q    <= count_q;
							end else begin
								out_status_q <= sclp_pkg::ST_INSERTED;
								out_occ_q    <= count_inc;
								count_q      <= count_inc;
							end
						end else begin
							// table full: evict oldest
							out_status_q <= sclp_pkg::ST_REPLACED;
							out_slot_q   <= to_slot(old_slot_q);
							out_name_q   <= old_name_q;
							out_rel_q    <= conn_q;
							out_occ_q    <= count_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_RELEASE: begin
					if (shift_en) begin
						if (head.key != '0) begin
							out_status_q <= sclp_pkg::ST_CLEARED;
							out_slot_q   <= to_slot(t_q);
							out_name_q   <= head.name;
							out_rel_q    <= 1'b1;
							out_occ_q    <= '0;
							out_last_q   <= 1'b0;
						end
						t_q <= t_next;
						if (last_step) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (can_load) begin
						count_q      <= '0;
						out_status_q <= sclp_pkg::ST_CLEARED;
						out_slot_q   <= '0;
						out_name_q   <= '0;
						out_rel_q    <= 1'b0;
						out_occ_q    <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_REJECT: begin
					if (can_load) begin
						out_status_q <= sclp_pkg::ST_REJECTED;
						out_slot_q   <= '0;
						out_name_q   <= '0;
						out_rel_q    <= 1'b0;
						out_occ_q    <= count_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot        = out_slot_q;
	assign rsp.found_name  = out_name_q;
	assign rsp.release_res = out_rel_q;
	assign rsp.occupied    = out_occ_q;
	assign rsp.last        = out_last_q;

endmodule

`default_nettype wire
